// File: rtl/core/cci_pkg.sv
// Shared payload types and relation codes of the circle intersection unit.
`default_nettype none

package cci_pkg;

	typedef struct packed {
		logic signed [31:0] first_center_x;
		logic signed [31:0] first_center_y;
		logic        [30:0] first_radius;
		logic signed [31:0] second_center_x;
		logic signed [31:0] second_center_y;
		logic        [30:0] second_radius;
	} query_t;

	typedef struct packed {
		logic        [1:0]  relation;
		logic signed [31:0] point_a_x;
		logic signed [31:0] point_a_y;
		logic signed [31:0] point_b_x;
		logic signed [31:0] point_b_y;
		logic               saturated;
	} answer_t;

	localparam logic [1:0] REL_NONE       = 2'd0;
	localparam logic [1:0] REL_COINCIDENT = 2'd1;
	localparam logic [1:0] REL_TANGENT    = 2'd2;
	localparam logic [1:0] REL_CROSSING   = 2'd3;

endpackage

`default_nettype wire

// File: rtl/core/cci_delay.sv
// Clock-enabled delay line that keeps side data aligned with the pipeline.
`default_nettype none

module cci_delay #(
	parameter int W = 8,
	parameter int N = 4
) (
	input  logic         clk,
	input  logic         ce,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] tap_s [N];

	always_ff @(posedge clk) begin
		if (ce) begin
			tap_s[0] <= d;
			for (int k = 1; k < N; k++) tap_s[k] <= tap_s[k-1];
		end
	end

	assign q = tap_s[N-1];

endmodule

`default_nettype wire

// File: rtl/core/cci_mul.sv
// Wide unsigned multiplier built from 32x32 partial products, three stages.
`default_nettype none

module cci_mul #(
	parameter int WA = 64,
	parameter int WB = 64
) (
	input  logic             clk,
	input  logic             ce,
	input  logic [WA-1:0]    a,
	input  logic [WB-1:0]    b,
	output logic [WA+WB-1:0] p
);

	localparam int NA   = (WA + 31) / 32;
	localparam int WAP  = NA * 32;
	localparam int WP   = WA + WB;
	localparam int WROW = WAP + 32;

	logic [WAP-1:0]  a_pad;
	logic [63:0]     b_pad;
	logic [63:0]     pp_s1 [NA][2];
	logic [WROW-1:0] even_w [2];
	logic [WROW-1:0] odd_w [2];
	logic [WROW-1:0] row_s2 [2];
	logic [WP-1:0]   p_s3;

	assign a_pad = WAP'(a);
	assign b_pad = 64'(b);

	always_ff @(posedge clk) begin
		if (ce) begin
			for (int i = 0; i < NA; i++) begin
				for (int j = 0; j < 2; j++) begin
					pp_s1[i][j] <= {32'd0, a_pad[32*i +: 32]} * {32'd0, b_pad[32*j +: 32]};
				end
			end
		end
	end

	// Products of even and of odd digits do not overlap, so each set packs into one word.
	always_comb begin
		for (int j = 0; j < 2; j++) begin
			even_w[j] = '0;
			odd_w[j]  = '0;
			for (int i = 0; i < NA; i++) begin
				if ((i & 1) == 0) begin
					even_w[j] = even_w[j] | (WROW'(pp_s1[i][j]) << (32 * i));
				end else begin
					odd_w[j] = odd_w[j] | (WROW'(pp_s1[i][j]) << (32 * i));
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			for (int j = 0; j < 2; j++) row_s2[j] <= even_w[j] + odd_w[j];
			p_s3 <= WP'(row_s2[0]) + (WP'(row_s2[1]) << 32);
		end
	end

	assign p = p_s3;

endmodule

`default_nettype wire

// File: rtl/core/cci_sqrt.sv
// Pipelined floor square root, one result bit per stage.
`default_nettype none

module cci_sqrt #(
	parameter int WQ = 96
) (
	input  logic            clk,
	input  logic            ce,
	input  logic [2*WQ-1:0] n,
	output logic [WQ-1:0]   root
);

	localparam int WR = 2 * WQ;

	logic [WR-1:0] rem_s  [1:WQ-1];
	logic [WQ-1:0] root_s [1:WQ];

	for (genvar k = 0; k < WQ; k++) begin : g_step
		localparam int B = WQ - 1 - k;
		logic [WR-1:0] rem_in;
		logic [WQ-1:0] root_in;
		logic [WR-1:0] trial;
		logic          take;

		if (k == 0) begin : g_first
			assign rem_in  = n;
			assign root_in = '0;
		end else begin : g_next
			assign rem_in  = rem_s[k];
			assign root_in = root_s[k];
		end

		// Setting bit B grows the square by 2*root*2^B + 2^(2B).
		assign trial = (WR'(root_in) << (B + 1)) | (WR'(1) << (2 * B));
		assign take  = rem_in >= trial;

		always_ff @(posedge clk) begin
			if (ce) root_s[k+1] <= take ? (root_in | (WQ'(1) << B)) : root_in;
		end

		if (k < WQ - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (ce) rem_s[k+1] <= take ? rem_in - trial : rem_in;
			end
		end
	end

	assign root = root_s[WQ];

endmodule

`default_nettype wire

// File: rtl/core/cci_div.sv
// Pipelined divider that rounds to nearest, halves away from zero.
`default_nettype none

module cci_div #(
	parameter int WN = 98,
	parameter int WD = 66,
	parameter int WQ = 33
) (
	input  logic          clk,
	input  logic          ce,
	input  logic [WN-1:0] num,
	input  logic [WD-1:0] den,
	output logic [WQ-1:0] q
);

	localparam int WV = WD + 1;
	localparam int WR = WV + WQ;

	logic [WR-1:0] rem_s [0:WQ-1];
	logic [WV-1:0] v_s   [0:WQ-1];
	logic [WQ-1:0] q_s   [1:WQ];

	// round(num/den) is floor((2*num + den) / (2*den)).
	always_ff @(posedge clk) begin
		if (ce) begin
			rem_s[0] <= (WR'(num) << 1) + WR'(den);
			v_s[0]   <= WV'(den) << 1;
		end
	end

	for (genvar k = 0; k < WQ; k++) begin : g_step
		localparam int B = WQ - 1 - k;
		logic [WQ-1:0] q_in;
		logic [WR-1:0] trial;
		logic          take;

		if (k == 0) begin : g_first
			assign q_in = '0;
		end else begin : g_next
			assign q_in = q_s[k];
		end

		assign trial = WR'(v_s[k]) << B;
		assign take  = rem_s[k] >= trial;

		always_ff @(posedge clk) begin
			if (ce) q_s[k+1] <= take ? (q_in | (WQ'(1) << B)) : q_in;
		end

		if (k < WQ - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (ce) begin
					rem_s[k+1] <= take ? rem_s[k] - trial : rem_s[k];
					v_s[k+1]   <= v_s[k];
				end
			end
		end
	end

	assign q = q_s[WQ];

endmodule

`default_nettype wire

// File: rtl/core/circle_circle_intersection_unit.sv
// Circle-circle intersection unit: a stall-held pipeline of exact integer arithmetic.
//
// An item on the query channel holds two circles (Q16.16 centers, unsigned radii).
// Each item yields exactly one item on the answer channel: the relation code and the
// two intersection points, saturated to 32 bits, zero when there is no single point set.
// Both channels move an item on a rising edge where valid is high and stall is low.
// A new item can be taken every cycle while query_stall is low. Its path runs through
// the squaring and multiplier stages, the 96-stage square roots of K*dy^2 and K*dx^2,
// a 34-stage rounding divider and the output stages.
// The whole pipeline advances together. While an answer waits under answer_stall,
// every stage holds its contents and query_stall is raised in the same cycle, so
// nothing is dropped or repeated; empty stages simply travel as bubbles.
// Reset clears all valid bits, so no answer appears until items are accepted; the
// data registers are not reset. The unit keeps no state from one item to the next.
`default_nettype none

module circle_circle_intersection_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              query_valid,
	output logic              query_stall,
	input  cci_pkg::query_t   query,
	output logic              answer_valid,
	input  logic              answer_stall,
	output cci_pkg::answer_t  answer
);

	localparam int MUL_LAT  = 3;
	localparam int SQRT_W   = 96;
	localparam int DIV_Q    = 33;
	localparam int DIV_LAT  = DIV_Q + 1;
	localparam int LAT      = 6 + 2 * MUL_LAT + SQRT_W + DIV_LAT + 2;
	localparam int DEND_DLY = 2 * MUL_LAT + SQRT_W;
	localparam int XY_DLY   = MUL_LAT + SQRT_W;
	localparam int SIDE_DLY = 2 * MUL_LAT + SQRT_W + DIV_LAT;

	logic           adv;
	logic [LAT-1:0] vld_s;

	assign adv          = !answer_valid || !answer_stall;
	assign query_stall  = !adv;
	assign answer_valid = vld_s[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[LAT-2:0], query_valid};
		end
	end

	// Stage 1: differences and radius sum/difference.
	logic [32:0] dx_s1, dy_s1;
	logic [31:0] sum_s1, cx_s1, cy_s1;
	logic [30:0] rd_s1, r1_s1, r2_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1  <= {query.second_center_x[31], query.second_center_x}
				- {query.first_center_x[31], query.first_center_x};
			dy_s1  <= {query.second_center_y[31], query.second_center_y}
				- {query.first_center_y[31], query.first_center_y};
			sum_s1 <= {1'b0, query.first_radius} + {1'b0, query.second_radius};
			rd_s1  <= (query.first_radius >= query.second_radius)
				? query.first_radius - query.second_radius
				: query.second_radius - query.first_radius;
			r1_s1  <= query.first_radius;
			r2_s1  <= query.second_radius;
			cx_s1  <= query.first_center_x;
			cy_s1  <= query.first_center_y;
		end
	end

	// Stage 2: magnitudes.
	logic [31:0] adx_s2, ady_s2, sum_s2, cx_s2, cy_s2;
	logic [30:0] rd_s2, r1_s2, r2_s2;
	logic        dxn_s2, dyn_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			adx_s2 <= dx_s1[32] ? 32'(33'd0 - dx_s1) : dx_s1[31:0];
			ady_s2 <= dy_s1[32] ? 32'(33'd0 - dy_s1) : dy_s1[31:0];
			dxn_s2 <= dx_s1[32];
			dyn_s2 <= dy_s1[32];
			sum_s2 <= sum_s1;
			rd_s2  <= rd_s1;
			r1_s2  <= r1_s1;
			r2_s2  <= r2_s1;
			cx_s2  <= cx_s1;
			cy_s2  <= cy_s1;
		end
	end

	// Stage 3: squares.
	logic [63:0] dx2_s3, dy2_s3, ss_s3;
	logic [61:0] dd_s3, r1s_s3, r2s_s3;
	logic [31:0] adx_s3, ady_s3, cx_s3, cy_s3;
	logic        dxn_s3, dyn_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			dx2_s3 <= {32'd0, adx_s2} * {32'd0, adx_s2};
			dy2_s3 <= {32'd0, ady_s2} * {32'd0, ady_s2};
			ss_s3  <= {32'd0, sum_s2} * {32'd0, sum_s2};
			dd_s3  <= {31'd0, rd_s2} * {31'd0, rd_s2};
			r1s_s3 <= {31'd0, r1_s2} * {31'd0, r1_s2};
			r2s_s3 <= {31'd0, r2_s2} * {31'd0, r2_s2};
			adx_s3 <= adx_s2;
			ady_s3 <= ady_s2;
			dxn_s3 <= dxn_s2;
			dyn_s3 <= dyn_s2;
			cx_s3  <= cx_s2;
			cy_s3  <= cy_s2;
		end
	end

	// Stage 4: squared center distance.
	logic [64:0] d2_s4;
	logic [63:0] ss_s4, dx2_s4, dy2_s4;
	logic [61:0] dd_s4, r1s_s4, r2s_s4;
	logic [31:0] adx_s4, ady_s4, cx_s4, cy_s4;
	logic        dxn_s4, dyn_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			d2_s4  <= {1'b0, dx2_s3} + {1'b0, dy2_s3};
			ss_s4  <= ss_s3;
			dd_s4  <= dd_s3;
			r1s_s4 <= r1s_s3;
			r2s_s4 <= r2s_s3;
			dx2_s4 <= dx2_s3;
			dy2_s4 <= dy2_s3;
			adx_s4 <= adx_s3;
			ady_s4 <= ady_s3;
			dxn_s4 <= dxn_s3;
			dyn_s4 <= dyn_s3;
			cx_s4  <= cx_s3;
			cy_s4  <= cy_s3;
		end
	end

	// Stage 5: classification and the two factors of K.
	logic [1:0]  rel_w;
	logic [64:0] ts_w, td_w;
	logic [1:0]  rel_s5;
	logic [65:0] p_s5, dend_s5;
	logic [63:0] ts_s5, td_s5, dx2_s5, dy2_s5;
	logic [61:0] r2s_s5;
	logic [31:0] adx_s5, ady_s5, cx_s5, cy_s5;
	logic        dxn_s5, dyn_s5;

	always_comb begin
		priority if (d2_s4 > {1'b0, ss_s4} || d2_s4 < 65'(dd_s4)) begin
			rel_w = cci_pkg::REL_NONE;
		end else if (d2_s4 == '0) begin
			rel_w = cci_pkg::REL_COINCIDENT;
		end else if (d2_s4 == {1'b0, ss_s4} || d2_s4 == 65'(dd_s4)) begin
			rel_w = cci_pkg::REL_TANGENT;
		end else begin
			rel_w = cci_pkg::REL_CROSSING;
		end
		ts_w = {1'b0, ss_s4} - d2_s4;
		td_w = d2_s4 - 65'(dd_s4);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rel_s5  <= rel_w;
			p_s5    <= 66'(r1s_s4) + 66'(d2_s4);
			ts_s5   <= ts_w[63:0];
			td_s5   <= td_w[63:0];
			dend_s5 <= {d2_s4, 1'b0};
			r2s_s5  <= r2s_s4;
			dx2_s5  <= dx2_s4;
			dy2_s5  <= dy2_s4;
			adx_s5  <= adx_s4;
			ady_s5  <= ady_s4;
			dxn_s5  <= dxn_s4;
			dyn_s5  <= dyn_s4;
			cx_s5   <= cx_s4;
			cy_s5   <= cy_s4;
		end
	end

	// Stage 6: a = r1^2 - r2^2 + d2 as sign and magnitude.
	logic [65:0] a_s6, dend_s6;
	logic        aneg_s6;
	logic [1:0]  rel_s6;
	logic [63:0] ts_s6, td_s6, dx2_s6, dy2_s6;
	logic [31:0] adx_s6, ady_s6, cx_s6, cy_s6;
	logic        dxn_s6, dyn_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			aneg_s6 <= p_s5 < 66'(r2s_s5);
			a_s6    <= (p_s5 < 66'(r2s_s5)) ? 66'(r2s_s5) - p_s5 : p_s5 - 66'(r2s_s5);
			dend_s6 <= dend_s5;
			rel_s6  <= rel_s5;
			ts_s6   <= ts_s5;
			td_s6   <= td_s5;
			dx2_s6  <= dx2_s5;
			dy2_s6  <= dy2_s5;
			adx_s6  <= adx_s5;
			ady_s6  <= ady_s5;
			dxn_s6  <= dxn_s5;
			dyn_s6  <= dyn_s5;
			cx_s6   <= cx_s5;
			cy_s6   <= cy_s5;
		end
	end

	// Chord foot numerators and K.
	logic [97:0]  nx_s9, ny_s9;
	logic [127:0] k_s9;
	logic [127:0] sq_s9;
	logic [65:0]  dend_s9, dend_s108;

	cci_mul #(.WA(66), .WB(32)) u_mul_nx (
		.clk(clk), .ce(adv), .a(a_s6), .b(adx_s6), .p(nx_s9)
	);
	cci_mul #(.WA(66), .WB(32)) u_mul_ny (
		.clk(clk), .ce(adv), .a(a_s6), .b(ady_s6), .p(ny_s9)
	);
	cci_mul #(.WA(64), .WB(64)) u_mul_k (
		.clk(clk), .ce(adv), .a(ts_s6), .b(td_s6), .p(k_s9)
	);
	cci_delay #(.W(128), .N(MUL_LAT)) u_dly_sq (
		.clk(clk), .ce(adv), .d({dx2_s6, dy2_s6}), .q(sq_s9)
	);
	cci_delay #(.W(66), .N(MUL_LAT)) u_dly_dend_xy (
		.clk(clk), .ce(adv), .d(dend_s6), .q(dend_s9)
	);
	cci_delay #(.W(66), .N(DEND_DLY)) u_dly_dend_h (
		.clk(clk), .ce(adv), .d(dend_s6), .q(dend_s108)
	);

	// Half chord: K*dy^2 gives the x offset, K*dx^2 the y offset.
	logic [191:0] ky_s12, kx_s12;
	logic [95:0]  rhx_s108, rhy_s108;
	logic [32:0]  mhx_s142, mhy_s142;

	cci_mul #(.WA(128), .WB(64)) u_mul_ky (
		.clk(clk), .ce(adv), .a(k_s9), .b(sq_s9[63:0]), .p(ky_s12)
	);
	cci_mul #(.WA(128), .WB(64)) u_mul_kx (
		.clk(clk), .ce(adv), .a(k_s9), .b(sq_s9[127:64]), .p(kx_s12)
	);
	cci_sqrt #(.WQ(SQRT_W)) u_sqrt_hx (
		.clk(clk), .ce(adv), .n(ky_s12), .root(rhx_s108)
	);
	cci_sqrt #(.WQ(SQRT_W)) u_sqrt_hy (
		.clk(clk), .ce(adv), .n(kx_s12), .root(rhy_s108)
	);
	cci_div #(.WN(96), .WD(66), .WQ(DIV_Q)) u_div_hx (
		.clk(clk), .ce(adv), .num(rhx_s108), .den(dend_s108), .q(mhx_s142)
	);
	cci_div #(.WN(96), .WD(66), .WQ(DIV_Q)) u_div_hy (
		.clk(clk), .ce(adv), .num(rhy_s108), .den(dend_s108), .q(mhy_s142)
	);

	// Chord foot offsets, held back to meet the half chord.
	logic [32:0] mx_s43, my_s43, mx_s142, my_s142;

	cci_div #(.WN(98), .WD(66), .WQ(DIV_Q)) u_div_x (
		.clk(clk), .ce(adv), .num(nx_s9), .den(dend_s9), .q(mx_s43)
	);
	cci_div #(.WN(98), .WD(66), .WQ(DIV_Q)) u_div_y (
		.clk(clk), .ce(adv), .num(ny_s9), .den(dend_s9), .q(my_s43)
	);
	cci_delay #(.W(66), .N(XY_DLY)) u_dly_xy (
		.clk(clk), .ce(adv), .d({mx_s43, my_s43}), .q({mx_s142, my_s142})
	);

	logic [1:0]  rel_s142;
	logic        aneg_s142, dxn_s142, dyn_s142;
	logic [31:0] cx_s142, cy_s142;

	cci_delay #(.W(69), .N(SIDE_DLY)) u_dly_side (
		.clk(clk), .ce(adv),
		.d({rel_s6, aneg_s6, dxn_s6, dyn_s6, cx_s6, cy_s6}),
		.q({rel_s142, aneg_s142, dxn_s142, dyn_s142, cx_s142, cy_s142})
	);

	// Stage 143: signed foot point and half chord.
	logic signed [34:0] x0_s143, y0_s143, hx_s143, hy_s143;
	logic [1:0]         rel_s143;
	logic signed [34:0] mx_w, my_w, mhx_w, mhy_w;

	always_comb begin
		mx_w  = signed'(35'(mx_s142));
		my_w  = signed'(35'(my_s142));
		mhx_w = signed'(35'(mhx_s142));
		mhy_w = signed'(35'(mhy_s142));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x0_s143  <= 35'(signed'(cx_s142)) + ((dxn_s142 ^ aneg_s142) ? -mx_w : mx_w);
			y0_s143  <= 35'(signed'(cy_s142)) + ((dyn_s142 ^ aneg_s142) ? -my_w : my_w);
			hx_s143  <= dyn_s142 ? -mhx_w : mhx_w;
			hy_s143  <= dxn_s142 ? -mhy_w : mhy_w;
			rel_s143 <= rel_s142;
		end
	end

	// Stage 144: points, clipping and the answer register.
	function automatic logic [32:0] clip(input logic signed [35:0] v);
		logic [32:0] r;
		if (v > 36'sd2147483647) begin
			r = {1'b1, 32'h7fff_ffff};
		end else if (v < -36'sd2147483648) begin
			r = {1'b1, 32'h8000_0000};
		end else begin
			r = {1'b0, v[31:0]};
		end
		return r;
	endfunction

	logic [32:0]       ax_w, ay_w, bx_w, by_w;
	logic              has_pts;
	cci_pkg::answer_t  ans_w, ans_s144;

	always_comb begin
		ax_w    = clip(36'(x0_s143) + 36'(hx_s143));
		ay_w    = clip(36'(y0_s143) - 36'(hy_s143));
		bx_w    = clip(36'(x0_s143) - 36'(hx_s143));
		by_w    = clip(36'(y0_s143) + 36'(hy_s143));
		has_pts = rel_s143 == cci_pkg::REL_TANGENT || rel_s143 == cci_pkg::REL_CROSSING;
		ans_w.relation  = rel_s143;
		ans_w.point_a_x = has_pts ? ax_w[31:0] : '0;
		ans_w.point_a_y = has_pts ? ay_w[31:0] : '0;
		ans_w.point_b_x = has_pts ? bx_w[31:0] : '0;
		ans_w.point_b_y = has_pts ? by_w[31:0] : '0;
		ans_w.saturated = has_pts && (ax_w[32] || ay_w[32] || bx_w[32] || by_w[32]);
	end

	always_ff @(posedge clk) begin
		if (adv) ans_s144 <= ans_w;
	end

	assign answer = ans_s144;

endmodule

`default_nettype wire

// File: rtl/core/cci_check.sv
// Port-level checks of the circle intersection unit and their binding.
`default_nettype none

module cci_check (
	input logic             clk,
	input logic             arst_n,
	input logic             query_stall,
	input logic             answer_valid,
	input logic             answer_stall,
	input cci_pkg::answer_t answer
);

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		answer_valid && answer_stall |=> answer_valid)
		else $error("answer_valid dropped while stalled");

	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		answer_valid && answer_stall |=> $stable(answer))
		else $error("answer changed while stalled");

	// The input side only waits when a finished answer is held back.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		query_stall |-> answer_valid && answer_stall)
		else $error("query stalled without a blocked answer");

	a_no_points: assert property (@(posedge clk) disable iff (!arst_n)
		answer_valid && (answer.relation == cci_pkg::REL_NONE
			|| answer.relation == cci_pkg::REL_COINCIDENT)
		|-> answer.point_a_x == '0 && answer.point_a_y == '0 && answer.point_b_x == '0
			&& answer.point_b_y == '0 && !answer.saturated)
		else $error("points present without an intersection");

	a_tangent: assert property (@(posedge clk) disable iff (!arst_n)
		answer_valid && answer.relation == cci_pkg::REL_TANGENT
		|-> answer.point_a_x == answer.point_b_x && answer.point_a_y == answer.point_b_y)
		else $error("tangent points differ");

endmodule

bind circle_circle_intersection_unit cci_check u_cci_check (
	.clk(clk),
	.arst_n(arst_n),
	.query_stall(query_stall),
	.answer_valid(answer_valid),
	.answer_stall(answer_stall),
	.answer(answer)
);

`default_nettype wire

// File: test/circle_circle_intersection_checker.sv
// Checker for the circle intersection unit: predicts each answer and compares it on arrival.
module circle_circle_intersection_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             query_valid,
	input  logic             query_stall,
	input  cci_pkg::query_t  query,
	input  logic             answer_valid,
	input  logic             answer_stall,
	input  cci_pkg::answer_t answer,
	output int               errors,
	output int               pending
);
	import cci_pkg::*;

	typedef logic [255:0] wide_t;

	answer_t expected_answers[$];

	function automatic wide_t floor_sqrt(wide_t num);
		wide_t res, cand;
		res = '0;
		for (int b = 127; b >= 0; b--) begin
			cand = res | (wide_t'(1) << b);
			if (cand * cand <= num)
				res = cand;
		end
		return res;
	endfunction

	// Rounds to nearest with halves going up, on magnitudes only.
	function automatic longint round_quot(wide_t num, wide_t den);
		wide_t q;
		q = (num + num + den) / (den + den);
		return longint'(q[63:0]);
	endfunction

	function automatic logic [31:0] clamp32(longint v, inout logic clipped);
		if (v > 64'sd2147483647) begin
			clipped = 1'b1;
			return 32'h7fff_ffff;
		end
		if (v < -64'sd2147483648) begin
			clipped = 1'b1;
			return 32'h8000_0000;
		end
		return v[31:0];
	endfunction

	function automatic answer_t predict_intersection(query_t q);
		answer_t res;
		longint cx, cy, dx, dy, x0, y0, hx, hy, m;
		wide_t adx, ady, r1, r2, rd, d2, s, dd, p, a, r2s, dend, k;
		logic a_neg, clipped;
		res = '0;
		clipped = 1'b0;
		cx = longint'(q.first_center_x);
		cy = longint'(q.first_center_y);
		dx = longint'(q.second_center_x) - cx;
		dy = longint'(q.second_center_y) - cy;
		adx = wide_t'(dx < 0 ? -dx : dx);
		ady = wide_t'(dy < 0 ? -dy : dy);
		r1 = wide_t'(q.first_radius);
		r2 = wide_t'(q.second_radius);
		rd = r1 > r2 ? r1 - r2 : r2 - r1;
		d2 = adx * adx + ady * ady;
		s = (r1 + r2) * (r1 + r2);
		dd = rd * rd;
		if (d2 > s || d2 < dd)
			return res;
		if (d2 == 0) begin
			res.relation = REL_COINCIDENT;
			return res;
		end
		res.relation = (d2 == s || d2 == dd) ? REL_TANGENT : REL_CROSSING;
		p = r1 * r1 + d2;
		r2s = r2 * r2;
		a_neg = p < r2s;
		a = a_neg ? r2s - p : p - r2s;
		dend = d2 + d2;
		m = round_quot(adx * a, dend);
		x0 = cx + (((dx < 0) != a_neg) ? -m : m);
		m = round_quot(ady * a, dend);
		y0 = cy + (((dy < 0) != a_neg) ? -m : m);
		k = (s - d2) * (d2 - dd);
		m = round_quot(floor_sqrt(k * ady * ady), dend);
		hx = dy < 0 ? -m : m;
		m = round_quot(floor_sqrt(k * adx * adx), dend);
		hy = dx < 0 ? -m : m;
		res.point_a_x = clamp32(x0 + hx, clipped);
		res.point_a_y = clamp32(y0 - hy, clipped);
		res.point_b_x = clamp32(x0 - hx, clipped);
		res.point_b_y = clamp32(y0 + hy, clipped);
		res.saturated = clipped;
		return res;
	endfunction

	assign pending = expected_answers.size();

	always @(posedge clk or negedge arst_n) begin
		answer_t want;
		if (!arst_n) begin
			errors <= 0;
		end else begin
			if (query_valid && !query_stall)
				expected_answers.push_back(predict_intersection(query));
			if (answer_valid && !answer_stall) begin
				if (expected_answers.size() == 0) begin
					$display("%0t: answer with no query pending: %p", $time, answer);
					errors <= errors + 1;
				end else begin
					want = expected_answers.pop_front();
					if (want.relation !== answer.relation)
						$display("%0t: relation expected %0d got %0d", $time,
							want.relation, answer.relation);
					if (want.point_a_x !== answer.point_a_x)
						$display("%0t: point_a_x expected %0d got %0d", $time,
							want.point_a_x, answer.point_a_x);
					if (want.point_a_y !== answer.point_a_y)
						$display("%0t: point_a_y expected %0d got %0d", $time,
							want.point_a_y, answer.point_a_y);
					if (want.point_b_x !== answer.point_b_x)
						$display("%0t: point_b_x expected %0d got %0d", $time,
							want.point_b_x, answer.point_b_x);
					if (want.point_b_y !== answer.point_b_y)
						$display("%0t: point_b_y expected %0d got %0d", $time,
							want.point_b_y, answer.point_b_y);
					if (want.saturated !== answer.saturated)
						$display("%0t: saturated expected %0b got %0b", $time,
							want.saturated, answer.saturated);
					if (want !== answer)
						errors <= errors + 1;
				end
			end
		end
	end
endmodule

// File: test/circle_circle_intersection_unit_tb.sv
// Testbench top for the circle intersection unit: clock, reset, stimulus and verdict.
module circle_circle_intersection_unit_tb;
	import cci_pkg::*;

	logic clk;
	logic arst_n;
	logic query_valid;
	logic query_stall;
	query_t query;
	logic answer_valid;
	logic answer_stall;
	answer_t answer;
	logic query_taken;
	int errors;
	int pending;
	int send_idle_pct;
	int recv_stall_pct;

	circle_circle_intersection_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.query_valid  (query_valid),
		.query_stall  (query_stall),
		.query        (query),
		.answer_valid (answer_valid),
		.answer_stall (answer_stall),
		.answer       (answer)
	);

	circle_circle_intersection_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.query_valid  (query_valid),
		.query_stall  (query_stall),
		.query        (query),
		.answer_valid (answer_valid),
		.answer_stall (answer_stall),
		.answer       (answer),
		.errors       (errors),
		.pending      (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("*** FAILED ***");
		$finish;
	end

	always @(posedge clk)
		query_taken <= query_valid && !query_stall;

	always @(negedge clk)
		answer_stall <= ($urandom_range(99) < recv_stall_pct);

	// Sends one item, with a random gap ahead of it, and holds it until taken.
	task automatic send_query(query_t q);
		while ($urandom_range(99) < send_idle_pct) begin
			query_valid = 1'b0;
			@(negedge clk);
		end
		query_valid = 1'b1;
		query = q;
		do @(negedge clk); while (!query_taken);
		query_valid = 1'b0;
	endtask

	task automatic send_circles(longint cx1, longint cy1, longint r1,
			longint cx2, longint cy2, longint r2);
		query_t q;
		q.first_center_x = cx1[31:0];
		q.first_center_y = cy1[31:0];
		q.first_radius = r1[30:0];
		q.second_center_x = cx2[31:0];
		q.second_center_y = cy2[31:0];
		q.second_radius = r2[30:0];
		send_query(q);
	endtask

	function automatic longint rand_signed(int bits);
		longint v;
		v = longint'({$urandom, $urandom}) >>> (64 - bits);
		return v;
	endfunction

	// Random pair with content chosen so that the circles usually touch or cross.
	task automatic send_random_query();
		query_t q;
		logic [191:0] raw;
		longint cx, cy, dx, dy, r1, r2, span, kind, unit;
		int mag;
		kind = longint'($urandom_range(99));
		mag = $urandom_range(4, 31);
		cx = rand_signed(32);
		cy = rand_signed(32);
		if (kind < 15) begin
			raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
			q = raw[189:0];
			send_query(q);
		end else if (kind < 35) begin
			// Tangent pair on a 3-4-5 triangle, outside or inside.
			unit = longint'($urandom) >> (32 - (mag > 28 ? 28 : mag));
			dx = 3 * unit;
			dy = 4 * unit;
			if ($urandom_range(1)) dx = -dx;
			if ($urandom_range(1)) dy = -dy;
			r1 = longint'($urandom_range(5)) * unit;
			r2 = $urandom_range(1) ? 5 * unit - r1 : 5 * unit + r1;
			if ($urandom_range(1))
				send_circles(cx, cy, r1, cx + dx, cy + dy, r2);
			else
				send_circles(cx, cy, r2, cx + dx, cy + dy, r1);
		end else begin
			dx = rand_signed(mag);
			dy = rand_signed(mag);
			span = (dx < 0 ? -dx : dx) + (dy < 0 ? -dy : dy) + 1;
			r1 = longint'({$urandom, $urandom} % 64'(span + 1));
			r2 = span - r1 + longint'({$urandom, $urandom} % 64'(2 * r1 + 1)) - r1;
			if (r2 < 0) r2 = -r2;
			if (r2 > 64'h7fff_ffff) r2 = 64'h7fff_ffff;
			if (r1 > 64'h7fff_ffff) r1 = 64'h7fff_ffff;
			send_circles(cx, cy, r1, cx + dx, cy + dy, r2);
		end
	endtask

	initial begin
		longint one;
		one = 64'sd65536;
		arst_n = 1'b0;
		query_valid = 1'b0;
		query = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed cases.
		send_circles(0, 0, 0, 0, 0, 0);
		send_circles(one, one, 3 * one, one, one, 3 * one);
		send_circles(0, 0, one, 5 * one, 0, one);
		send_circles(0, 0, 5 * one, one, 0, one);
		send_circles(0, 0, one, 2 * one, 0, one);
		send_circles(one, 0, one, 0, 0, 2 * one);
		send_circles(0, 0, 2 * one, one, 0, one);
		send_circles(0, 0, 5 * one, 6 * one, 8 * one, 5 * one);
		send_circles(0, 0, 0, 3 * one, 4 * one, 5 * one);
		send_circles(0, 0, 0, 0, 0, one);
		send_circles(7, -3, 5, 7, -3, 5);
		send_circles(-64'sd2147483648, -64'sd2147483648, 64'h7fff_ffff,
			64'sd2147483647, 64'sd2147483647, 64'h7fff_ffff);
		send_circles(-64'sd2147483648, 0, 64'h7fff_ffff,
			64'sd2147483647, 0, 64'h7fff_ffff);
		send_circles(64'sd2147483647, 64'sd2147483647, 64'h7fff_ffff,
			64'sd2147483646, 64'sd2147483647, 64'h7fff_ffff);
		send_circles(-64'sd2147483648, -64'sd2147483648, 64'h7fff_fff0,
			-64'sd2147483647, -64'sd2147483648, 64'h7fff_fff0);
		send_circles(0, 0, 64'h7fff_ffff, 64'sd2147483647, 0, 0);
		send_circles(0, 0, 64'h7fff_ffff, 0, 0, 0);
		send_circles(-5 * one, 2 * one, 3 * one, -one, -one, 2 * one);
		send_circles(0, 0, 1, 1, 1, 1);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
				default: begin send_idle_pct = 22; recv_stall_pct = 22; end
			endcase
			repeat (375) send_random_query();
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;

		while (pending != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
